// File: src/msrh_pkg.sv
// Shared constants, register indexes and the arctangent table for the
// magnetometer sample ring. No dependencies.
`default_nettype none
package msrh_pkg;

  // Field widths fixed by the item layout.
  localparam int RAW_W   = 16;
  localparam int OFF_W   = 17;
  localparam int SCL_W   = 16;
  localparam int FIELD_W = 19;
  localparam int HEAD_W  = 15;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 3;

  // Defaults handed to the top-level parameters.
  localparam int RING_DEPTH_DEF   = 16;
  localparam int PHASE_PERIOD_DEF = 40;
  localparam int CORDIC_STEPS_DEF = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z  = 3'd5;

  localparam logic signed [SCL_W-1:0] SCALE_ONE = 16'sd16384;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // CORDIC datapath widths.
  localparam int CRD_W   = 30;
  localparam int ANG_W   = 27;
  localparam int ATAN_W  = 22;
  localparam int FULL_TURN = 23040;
  localparam logic signed [ANG_W-1:0] HALF_TURN_ANG = 27'sd11796480;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic [ATAN_W-1:0] atan_of(input logic [4:0] i);
    logic [ATAN_W-1:0] a;
    case (i)
      5'd0:  a = 22'd2949120;
      5'd1:  a = 22'd1740967;
      5'd2:  a = 22'd919879;
      5'd3:  a = 22'd466945;
      5'd4:  a = 22'd234379;
      5'd5:  a = 22'd117304;
      5'd6:  a = 22'd58666;
      5'd7:  a = 22'd29335;
      5'd8:  a = 22'd14668;
      5'd9:  a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      5'd20: a = 22'd4;
      5'd21: a = 22'd2;
      5'd22: a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: src/magnetometer_sample_ring_with_heading_top.sv
// Top level of the magnetometer sample ring: calibration lanes, ring RAM,
// CORDIC heading unit. Depends on msrh_pkg, msrh_cal_lane, msrh_ram, msrh_cordic.
`default_nettype none
// A push item is calibrated by three side-by-side axis lanes (registered
// product, then rounding) and then written into the ring one copy per cycle,
// three copies (two on the last push of every PHASE_PERIOD). A pop reads the
// ring RAM (registered read) and runs the iterative CORDIC, one micro-rotation
// per cycle; an empty pop goes straight to the output stage. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is taken. The ring holds no reset state beyond its pointers
// and count.
module magnetometer_sample_ring_with_heading_top #(
  parameter int RING_DEPTH   = msrh_pkg::RING_DEPTH_DEF,
  parameter int PHASE_PERIOD = msrh_pkg::PHASE_PERIOD_DEF,
  parameter int CORDIC_STEPS = msrh_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_operation,
  input  wire logic signed [msrh_pkg::RAW_W-1:0]     in_raw_x,
  input  wire logic signed [msrh_pkg::RAW_W-1:0]     in_raw_y,
  input  wire logic signed [msrh_pkg::RAW_W-1:0]     in_raw_z,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       out_valid_res,
  output logic signed [msrh_pkg::FIELD_W-1:0]        out_field_x,
  output logic signed [msrh_pkg::FIELD_W-1:0]        out_field_y,
  output logic signed [msrh_pkg::FIELD_W-1:0]        out_field_z,
  output logic [msrh_pkg::HEAD_W-1:0]                out_heading,
  output logic [$clog2(RING_DEPTH+1)-1:0]            out_entries_left,
  input  wire logic                                  cfg_we,
  input  wire logic [msrh_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [msrh_pkg::CFG_W-1:0]            cfg_data
);
  import msrh_pkg::*;

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CW    = $clog2(RING_DEPTH+1);
  localparam int PW    = $clog2(PHASE_PERIOD);
  localparam int ENT_W = 3 * FIELD_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CAL, S_WR, S_RD, S_RDW, S_CORD, S_OUT
  } state_t;

  state_t state_r;
  logic signed [RAW_W-1:0] rx_r, ry_r, rz_r;
  logic signed [OFF_W-1:0] off_x_r, off_y_r, off_z_r;
  logic signed [SCL_W-1:0] scl_x_r, scl_y_r, scl_z_r;
  logic [AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [CW-1:0] cnt_r;
  logic [PW-1:0] phase_r;
  logic [1:0]    copy_r;
  logic signed [FIELD_W-1:0] cal_x, cal_y, cal_z;
  logic signed [FIELD_W-1:0] res_x_r, res_y_r, res_z_r;
  logic [HEAD_W-1:0] res_head_r;
  logic [CW-1:0]     res_left_r;
  logic              res_vld_r;
  logic              ram_we;
  logic [ENT_W-1:0]  ram_rdata;
  logic              crd_start, crd_done;
  logic [HEAD_W-1:0] crd_heading;
  logic              out_valid_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      scl_x_r <= SCALE_ONE;
      scl_y_r <= SCALE_ONE;
      scl_z_r <= SCALE_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X: off_x_r <= $signed(cfg_data);
        REG_OFFSET_Y: off_y_r <= $signed(cfg_data);
        REG_OFFSET_Z: off_z_r <= $signed(cfg_data);
        REG_SCALE_X:  scl_x_r <= $signed(cfg_data[SCL_W-1:0]);
        REG_SCALE_Y:  scl_y_r <= $signed(cfg_data[SCL_W-1:0]);
        REG_SCALE_Z:  scl_z_r <= $signed(cfg_data[SCL_W-1:0]);
        default: ;
      endcase
    end
  end

  // Axis lanes: x from raw y, y from negated raw x, z unchanged.
  msrh_cal_lane u_lane_x (
    .clk(clk), .axis(OFF_W'(ry_r)), .offset(off_x_r), .scale(scl_x_r), .value(cal_x)
  );
  msrh_cal_lane u_lane_y (
    .clk(clk), .axis(-OFF_W'(rx_r)), .offset(off_y_r), .scale(scl_y_r), .value(cal_y)
  );
  msrh_cal_lane u_lane_z (
    .clk(clk), .axis(OFF_W'(rz_r)), .offset(off_z_r), .scale(scl_z_r), .value(cal_z)
  );

  // Ring storage: merged lane results form one entry.
  assign ram_we = (state_r == S_WR);

  msrh_ram #(.WIDTH(ENT_W), .DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .we(ram_we), .waddr(wp_r), .wdata({cal_x, cal_y, cal_z}),
    .raddr(rp_r), .rdata(ram_rdata)
  );

  // Heading unit starts when the read data arrives.
  assign crd_start = (state_r == S_RDW);

  msrh_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(crd_start),
    .fx($signed(ram_rdata[ENT_W-1 -: FIELD_W])),
    .fy($signed(ram_rdata[2*FIELD_W-1 -: FIELD_W])),
    .done(crd_done), .heading(crd_heading)
  );

  // Pointer wrap for any ring depth.
  assign wp_nxt = (wp_r == AW'(RING_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_nxt = (rp_r == AW'(RING_DEPTH - 1)) ? '0 : rp_r + 1'b1;

  // Sequencer, ring bookkeeping and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
      phase_r     <= '0;
      copy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The output slot empties when its item is taken, unless a new one loads.
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            rx_r <= in_raw_x;
            ry_r <= in_raw_y;
            rz_r <= in_raw_z;
            if (in_operation == OP_PUSH) begin
              state_r <= S_CAL;
            end else if (cnt_r == '0) begin
              res_vld_r  <= 1'b0;
              res_x_r    <= '0;
              res_y_r    <= '0;
              res_z_r    <= '0;
              res_head_r <= '0;
              res_left_r <= '0;
              state_r    <= S_OUT;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_CAL: begin
          copy_r  <= (phase_r < PW'(PHASE_PERIOD - 1)) ? 2'd2 : 2'd1;
          state_r <= S_WR;
        end
        S_WR: begin
          wp_r <= wp_nxt;
          if (cnt_r == CW'(RING_DEPTH)) begin
            rp_r <= rp_nxt;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (copy_r == 2'd0) begin
            phase_r <= (phase_r == PW'(PHASE_PERIOD - 1)) ? '0 : phase_r + 1'b1;
            state_r <= S_IDLE;
          end else begin
            copy_r <= copy_r - 1'b1;
          end
        end
        S_RD: begin
          state_r <= S_RDW;
        end
        S_RDW: begin
          res_vld_r  <= 1'b1;
          res_x_r    <= $signed(ram_rdata[ENT_W-1 -: FIELD_W]);
          res_y_r    <= $signed(ram_rdata[2*FIELD_W-1 -: FIELD_W]);
          res_z_r    <= $signed(ram_rdata[FIELD_W-1:0]);
          res_left_r <= cnt_r - 1'b1;
          rp_r       <= rp_nxt;
          cnt_r      <= cnt_r - 1'b1;
          state_r    <= S_CORD;
        end
        S_CORD: begin
          if (crd_done) begin
            res_head_r <= crd_heading;
            state_r    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r      <= 1'b1;
            out_valid_res    <= res_vld_r;
            out_field_x      <= res_x_r;
            out_field_y      <= res_y_r;
            out_field_z      <= res_z_r;
            out_heading      <= res_head_r;
            out_entries_left <= res_left_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // The count never exceeds the ring depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(RING_DEPTH))
    else $error("ring count above depth");

  // A heading run only starts on a ring that holds an entry.
  a_start_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    crd_start |-> (cnt_r != '0))
    else $error("heading started on empty ring");

  // Writing into a full ring keeps it full.
  a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && cnt_r == CW'(RING_DEPTH)) |=> (cnt_r == CW'(RING_DEPTH)))
    else $error("full ring lost an entry on write");

  // An output slot is never overwritten while its item is stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && state_r == S_OUT) |=> $stable(out_heading))
    else $error("stalled result overwritten");

endmodule
`default_nettype wire

// File: src/msrh_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`default_nettype none
module msrh_ram #(
  parameter int WIDTH = 57,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/msrh_cal_lane.sv
// One calibration lane: offset subtract, Q2.14 scale, round and saturate.
// Depends on msrh_pkg.
`default_nettype none
module msrh_cal_lane (
  input  wire logic                               clk,
  input  wire logic signed [msrh_pkg::OFF_W-1:0]  axis,
  input  wire logic signed [msrh_pkg::OFF_W-1:0]  offset,
  input  wire logic signed [msrh_pkg::SCL_W-1:0]  scale,
  output logic signed [msrh_pkg::FIELD_W-1:0]     value
);
  import msrh_pkg::*;

  localparam int D_W = OFF_W + 1;
  localparam int P_W = D_W + SCL_W;
  localparam int V_W = P_W + 1 - 14;

  logic signed [D_W-1:0] diff;
  logic signed [P_W-1:0] prod_r;
  logic signed [P_W:0]   rnd;
  logic signed [V_W-1:0] shifted;

  // Exact difference and product, registered before the rounding.
  assign diff = D_W'(axis) - D_W'(offset);

  always_ff @(posedge clk) begin
    prod_r <= diff * P_W'(scale);
  end

  // Round half up and clamp to the field range.
  assign rnd     = (P_W+1)'(prod_r) + (P_W+1)'(8192);
  assign shifted = V_W'(rnd >>> 14);

  always_comb begin
    if (shifted > V_W'(262143)) begin
      value = 19'sd262143;
    end else if (shifted < -V_W'(262144)) begin
      value = -19'sd262144;
    end else begin
      value = FIELD_W'(shifted);
    end
  end

endmodule
`default_nettype wire

// File: src/msrh_cordic.sv
// Iterative vectoring CORDIC for heading = atan2(-x, y) in 1/64 degree.
// Depends on msrh_pkg.
`default_nettype none
module msrh_cordic #(
  parameter int CORDIC_STEPS = msrh_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [msrh_pkg::FIELD_W-1:0] fx,
  input  wire logic signed [msrh_pkg::FIELD_W-1:0] fy,
  output logic                                   done,
  output logic [msrh_pkg::HEAD_W-1:0]            heading
);
  import msrh_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int H_W = ANG_W - 9;

  logic signed [CRD_W-1:0] xc_r, yc_r, xin, yin, dx, dy;
  logic signed [ANG_W-1:0] ang_r, atan_s, ang_rnd;
  logic [STEP_W-1:0]       step_r;
  logic                    busy_r, done_r, zero_r;
  logic signed [H_W-1:0]   h, h_wrap;

  // Rotated start vector: X = y * 256, Y = -x * 256.
  assign xin = $signed({{(CRD_W-FIELD_W-8){fy[FIELD_W-1]}}, fy, 8'b0});
  assign yin = -$signed({{(CRD_W-FIELD_W-8){fx[FIELD_W-1]}}, fx, 8'b0});

  assign dx     = yc_r >>> step_r;
  assign dy     = xc_r >>> step_r;
  assign atan_s = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_of(5'(step_r))});

  // One micro-rotation per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        zero_r <= (fx == '0) && (fy == '0);
        if (xin < 0) begin
          xc_r  <= -xin;
          yc_r  <= -yin;
          ang_r <= HALF_TURN_ANG;
        end else begin
          xc_r  <= xin;
          yc_r  <= yin;
          ang_r <= '0;
        end
      end else if (busy_r) begin
        if (yc_r >= 0) begin
          xc_r  <= xc_r + dx;
          yc_r  <= yc_r - dy;
          ang_r <= ang_r + atan_s;
        end else begin
          xc_r  <= xc_r - dx;
          yc_r  <= yc_r + dy;
          ang_r <= ang_r - atan_s;
        end
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  // Round to 1/64 degree and wrap into one turn.
  assign ang_rnd = ang_r + ANG_W'(512);
  assign h       = H_W'(ang_rnd >>> 10);

  always_comb begin
    if (h < 0) begin
      h_wrap = h + H_W'(FULL_TURN);
    end else if (h >= H_W'(FULL_TURN)) begin
      h_wrap = h - H_W'(FULL_TURN);
    end else begin
      h_wrap = h;
    end
  end

  assign done    = done_r;
  assign heading = zero_r ? '0 : HEAD_W'(h_wrap);

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the magnetometer sample ring with heading.
// Depends on msrh_pkg and magnetometer_sample_ring_with_heading_top.
`timescale 1ns / 100ps
`default_nettype none

// One expected or observed pop result.
typedef struct packed {
  logic        vld;
  logic [18:0] fx;
  logic [18:0] fy;
  logic [18:0] fz;
  logic [14:0] hdg;
  logic [4:0]  left;
} pop_result_t;

// Holds the expected pop results and tracks the ring, pointers and calibration.
class ring_scoreboard;
  pop_result_t pending_pops[$];
  longint      off[3];
  longint      scl[3];
  longint      ring_x[16], ring_y[16], ring_z[16];
  int          wr_ptr, rd_ptr, count, phase;
  int          errors;
  int          pops_checked;
  int          valid_pops;

  function new();
    off = '{0, 0, 0};
    scl = '{16384, 16384, 16384};
    wr_ptr = 0; rd_ptr = 0; count = 0; phase = 0;
    errors = 0; pops_checked = 0; valid_pops = 0;
  endfunction

  function void set_register(int idx, logic [16:0] val);
    if (idx < 3) off[idx] = longint'($signed(val));
    else if (idx < 6) scl[idx-3] = longint'($signed(val[15:0]));
  endfunction

  // Divides by 2^n rounding toward minus infinity.
  function longint floor_div(longint v, int n);
    return v >>> n;
  endfunction

  function longint calibrate(longint raw, longint o, longint s);
    longint v;
    v = floor_div((raw - o) * s + 8192, 14);
    if (v > 262143) v = 262143;
    if (v < -262144) v = -262144;
    return v;
  endfunction

  // Vectoring CORDIC of the (y, -x) vector, angle in 1/64 degree.
  function longint heading_of(longint fx, longint fy);
    longint xc, yc, ang, dx, dy, h;
    if (fx == 0 && fy == 0) return 0;
    xc = fy * 256;
    yc = -fx * 256;
    ang = 0;
    if (xc < 0) begin
      xc = -xc; yc = -yc; ang = 180 * 65536;
    end
    for (int i = 0; i < 16; i++) begin
      dx = yc >>> i;
      dy = xc >>> i;
      if (yc >= 0) begin
        xc += dx; yc -= dy; ang += longint'(msrh_pkg::atan_of(5'(i)));
      end else begin
        xc -= dx; yc += dy; ang -= longint'(msrh_pkg::atan_of(5'(i)));
      end
    end
    h = floor_div(ang + 512, 10);
    if (h < 0) h += 23040;
    if (h >= 23040) h -= 23040;
    return h;
  endfunction

  // Notes an accepted item and queues the result it causes.
  function void note_item(logic op, logic signed [15:0] rx, logic signed [15:0] ry,
                          logic signed [15:0] rz);
    longint      cx, cy, cz;
    int          copies;
    pop_result_t r;
    if (op == msrh_pkg::OP_PUSH) begin
      cx = calibrate(longint'(ry), off[0], scl[0]);
      cy = calibrate(-longint'(rx), off[1], scl[1]);
      cz = calibrate(longint'(rz), off[2], scl[2]);
      copies = (phase < 39) ? 3 : 2;
      for (int k = 0; k < copies; k++) begin
        ring_x[wr_ptr] = cx; ring_y[wr_ptr] = cy; ring_z[wr_ptr] = cz;
        wr_ptr = (wr_ptr + 1) % 16;
        count++;
        if (count > 16) begin
          count = 16;
          rd_ptr = (rd_ptr + 1) % 16;
        end
      end
      phase = (phase + 1) % 40;
    end else begin
      r = '0;
      if (count != 0) begin
        r.vld = 1'b1;
        r.fx = ring_x[rd_ptr][18:0];
        r.fy = ring_y[rd_ptr][18:0];
        r.fz = ring_z[rd_ptr][18:0];
        r.hdg = 15'(heading_of(ring_x[rd_ptr], ring_y[rd_ptr]));
        rd_ptr = (rd_ptr + 1) % 16;
        count--;
        r.left = 5'(count);
      end
      pending_pops.push_back(r);
    end
  endfunction

  function void report(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endfunction

  // Compares one accepted result with the oldest expectation.
  function void check_result(pop_result_t got);
    pop_result_t want;
    if (pending_pops.size() == 0) begin
      $display("mismatch: result with nothing expected");
      errors++;
      return;
    end
    want = pending_pops.pop_front();
    pops_checked++;
    if (want.vld) valid_pops++;
    if (got.vld !== want.vld) report("valid_res", got.vld, want.vld);
    if (got.fx !== want.fx) report("field_x", $signed(got.fx), $signed(want.fx));
    if (got.fy !== want.fy) report("field_y", $signed(got.fy), $signed(want.fy));
    if (got.fz !== want.fz) report("field_z", $signed(got.fz), $signed(want.fz));
    if (got.hdg !== want.hdg) report("heading", got.hdg, want.hdg);
    if (got.left !== want.left) report("entries_left", got.left, want.left);
  endfunction
endclass

module testbench;
  import msrh_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_operation;
  logic signed [15:0] in_raw_x, in_raw_y, in_raw_z;
  logic out_valid;
  logic out_stall;
  logic out_valid_res;
  logic signed [18:0] out_field_x, out_field_y, out_field_z;
  logic [14:0] out_heading;
  logic [4:0]  out_entries_left;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  ring_scoreboard sb;
  bit  long_hold;
  int  pushes_sent;

  magnetometer_sample_ring_with_heading_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_raw_x(in_raw_x), .in_raw_y(in_raw_y), .in_raw_z(in_raw_z),
    .out_valid(out_valid), .out_stall(out_stall), .out_valid_res(out_valid_res),
    .out_field_x(out_field_x), .out_field_y(out_field_y), .out_field_z(out_field_z),
    .out_heading(out_heading), .out_entries_left(out_entries_left),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one, sometimes none.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item and waits until it is accepted.
  task automatic send_item(logic op, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
    in_valid <= 1'b1;
    in_operation <= op;
    in_raw_x <= rx; in_raw_y <= ry; in_raw_z <= rz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, rx, ry, rz);
    if (op == OP_PUSH) pushes_sent++;
  endtask

  // Sends an item, then idles for a random gap.
  task automatic send_with_gap(logic op, logic [15:0] rx, logic [15:0] ry,
                               logic [15:0] rz);
    int g;
    send_item(op, rx, ry, rz);
    g = gap_length();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Waits for every expected result, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pops.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, val);
  endtask

  // Writes all six registers: offsets from -omax to omax, scales from the given range less 32768.
  task automatic write_all(int omax, int smin, int smax);
    write_reg(REG_OFFSET_X, 17'($signed($urandom_range(0, 2 * omax)) - omax));
    write_reg(REG_OFFSET_Y, 17'($signed($urandom_range(0, 2 * omax)) - omax));
    write_reg(REG_OFFSET_Z, 17'($signed($urandom_range(0, 2 * omax)) - omax));
    write_reg(REG_SCALE_X, 17'($urandom_range(smin, smax) - 32768));
    write_reg(REG_SCALE_Y, 17'($urandom_range(smin, smax) - 32768));
    write_reg(REG_SCALE_Z, 17'($urandom_range(smin, smax) - 32768));
  endtask

  // One random phase: pushes and pops mixed at random, a little over half of them pops.
  task automatic random_phase(int n, int amp);
    logic op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < 55) ? OP_POP : OP_PUSH;
      if (amp >= 32768)
        send_with_gap(op, 16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_with_gap(op, 16'($urandom_range(0, 2 * amp) - amp),
                      16'($urandom_range(0, 2 * amp) - amp),
                      16'($urandom_range(0, 2 * amp) - amp));
    end
  endtask

  // Receiver: random stalls, one long hold-off, and result checking.
  initial begin
    int g;
    pop_result_t got;
    out_stall = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      g = gap_length();
      out_stall <= (g != 0);
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = '{out_valid_res, out_field_x, out_field_y, out_field_z,
                out_heading, out_entries_left};
        sb.check_result(got);
      end
    end
  end

  // Stimulus.
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0; in_operation = OP_PUSH;
    in_raw_x = '0; in_raw_y = '0; in_raw_z = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    long_hold = 1'b0; pushes_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, zero vector, negative y, extremes, raw ignored on pop.
    send_item(OP_POP, 16'h7fff, 16'h8000, 16'h1234);
    send_item(OP_PUSH, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_POP, 16'hffff, 16'hffff, 16'hffff);
    send_item(OP_PUSH, 16'h0064, 16'h0000, 16'h0000);
    send_item(OP_PUSH, 16'h8000, 16'h7fff, 16'h8000);
    send_item(OP_PUSH, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(OP_PUSH, 16'h0000, 16'h0321, 16'hffff);
    send_item(OP_PUSH, 16'hfff0, 16'hfff0, 16'h0001);
    for (int i = 0; i < 17; i++) send_item(OP_POP, 16'h5555, 16'haaaa, 16'h0f0f);
    drain();

    // Extreme settings: largest offsets and scales to force saturation.
    write_reg(REG_OFFSET_X, 17'h10000);
    write_reg(REG_OFFSET_Y, 17'h0ffff);
    write_reg(REG_OFFSET_Z, 17'h10000);
    write_reg(REG_SCALE_X, 17'h08000);
    write_reg(REG_SCALE_Y, 17'h07fff);
    write_reg(REG_SCALE_Z, 17'h07fff);
    random_phase(120, 32768);
    drain();

    // Overfill: the receiver holds off while items keep coming.
    long_hold = 1'b1;
    random_phase(100, 32768);
    drain();

    write_all(65535, 0, 65535);
    random_phase(200, 32768);
    drain();

    write_all(200, 16384 + 8000, 16384 + 32000);
    random_phase(300, 2000);
    drain();

    write_reg(REG_OFFSET_X, 17'h00000);
    write_reg(REG_OFFSET_Y, 17'h00000);
    write_reg(REG_OFFSET_Z, 17'h00000);
    write_reg(REG_SCALE_X, 17'(SCALE_ONE));
    write_reg(REG_SCALE_Y, 17'(SCALE_ONE));
    write_reg(REG_SCALE_Z, 17'(SCALE_ONE));
    random_phase(300, 32768);
    drain();

    $display("covered %0d pushes and %0d pops, %0d of them returning an entry",
             pushes_sent, sb.pops_checked, sb.valid_pops);
    $display("settings ran from unity gain through extreme offsets and scales");
    if (sb.errors == 0 && sb.pending_pops.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

`default_nettype wire

// File: dv/msrh_atan_note.sv
// Unused.
